/* rtl/leib_pkg.sv */
// Shared types, constants and pointer helpers for the line editing input buffer.
// Depends on nothing; used by line_editing_input_buffer.
`timescale 1ns / 1ps

package leib_pkg;

   localparam int BufferDepth = 128;
   localparam int PtrMod      = 2 * BufferDepth;
   localparam int AddrWidth   = $clog2(BufferDepth);
   localparam int PtrWidth    = $clog2(PtrMod);

   typedef logic [PtrWidth-1:0]  ptr_type;
   typedef logic [AddrWidth-1:0] addr_type;
   typedef logic [7:0]           char_type;
   typedef logic [2:0]           status_type;

   localparam char_type KeyNone = 8'h00;
   localparam char_type KeyCr   = 8'h0D;
   localparam char_type KeyNl   = 8'h0A;
   localparam char_type KeyEof  = 8'h04;
   localparam char_type KeyKill = 8'h15;
   localparam char_type KeyBs   = 8'h08;
   localparam char_type KeyDel  = 8'h7F;
   localparam char_type KeyDump = 8'h10;

   localparam char_type EraseMax = 8'hFF;

   localparam status_type RdChar    = 3'd0;
   localparam status_type RdNewline = 3'd1;
   localparam status_type RdEofUsed = 3'd2;
   localparam status_type RdEofKept = 3'd3;
   localparam status_type RdEmpty   = 3'd4;

   localparam int ReqDataWidth = 16;

   typedef enum logic [3:0] {
      StIdle = 4'b0001,
      StKill = 4'b0010,
      StRead = 4'b0100,
      StOut  = 4'b1000
   } state_type;

   typedef struct packed {
      logic [1:0] pad;
      status_type read_status;
      char_type   read_char;
      logic       dump_request;
      logic       line_ready;
      char_type   erase_count;
      char_type   echo_char;
      logic       echo_valid;
   } rsp_type;

   localparam int RspDataWidth = $bits(rsp_type);

   function automatic ptr_type ptr_inc(input ptr_type p);
      ptr_type r;
      if (p == ptr_type'(PtrMod - 1)) begin
         r = '0;
      end else begin
         r = p + ptr_type'(1);
      end
      return r;
   endfunction

   function automatic ptr_type ptr_dec(input ptr_type p);
      ptr_type r;
      if (p == '0) begin
         r = ptr_type'(PtrMod - 1);
      end else begin
         r = p - ptr_type'(1);
      end
      return r;
   endfunction

   function automatic ptr_type ptr_dist(input ptr_type a, input ptr_type b);
      ptr_type r;
      if (a >= b) begin
         r = a - b;
      end else begin
         r = a - b + ptr_type'(PtrMod);
      end
      return r;
   endfunction

   function automatic addr_type ptr_slot(input ptr_type p);
      ptr_type r;
      if (p >= ptr_type'(BufferDepth)) begin
         r = p - ptr_type'(BufferDepth);
      end else begin
         r = p;
      end
      return r[AddrWidth-1:0];
   endfunction

endpackage

/* rtl/leib_ram.sv */
// Generic single-clock RAM: one write port, one read port, registered read.
// Depends on nothing.
`timescale 1ns / 1ps

module leib_ram #(
   parameter int Width = 8,
   parameter int Depth = 128
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);

   logic [Width-1:0] mem [Depth];
   logic [Width-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/line_editing_input_buffer.sv */
// Canonical line editing buffer: a character RAM with read, commit and edit pointers.
// Depends on leib_pkg and leib_ram.
`timescale 1ns / 1ps
//
// channel | dir | handshake              | payload
// req     | in  | req_tvalid/req_tready  | req_tuser cmd, req_tdata key_code, first_of_read
// rsp     | out | rsp_tvalid/rsp_tready  | rsp_tdata result fields
//
// Dump, erase one, store and empty read go from idle straight to the output state;
// a character read passes through StRead for its RAM read. Kill line walks StKill,
// one RAM read per erased character, and stops at the commit pointer or at a newline.
// A request is taken only in idle; one result may wait in the output register meanwhile.
// Synchronous reset clears pointers and control; the character RAM is not cleared.

module line_editing_input_buffer (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [leib_pkg::ReqDataWidth-1:0]    req_tdata,  // key_code[7:0], first_of_read[8]
   input  logic                                 req_tuser,  // cmd
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [leib_pkg::RspDataWidth-1:0]    rsp_tdata   // echo_valid, echo_char, erase_count,
                                                            // line_ready, dump_request, read_char,
                                                            // read_status, zero pad
);

   leib_pkg::state_type state_ff, state_in;
   leib_pkg::ptr_type   read_ff, read_in;
   leib_pkg::ptr_type   commit_ff, commit_in;
   leib_pkg::ptr_type   edit_ff, edit_in;
   logic                first_ff, first_in;
   leib_pkg::rsp_type   res_ff, res_in;
   leib_pkg::rsp_type   rsp_ff, rsp_in;
   logic                rsp_valid_ff, rsp_valid_in;

   logic                wr_en;
   leib_pkg::addr_type  wr_addr;
   leib_pkg::char_type  wr_data;
   logic                rd_en;
   leib_pkg::addr_type  rd_addr;
   leib_pkg::char_type  rd_data;

   leib_pkg::char_type  req_key;
   logic                req_first;
   leib_pkg::char_type  store_char;
   leib_pkg::ptr_type   edit_dec, edit_dec2, edit_inc, read_inc;

   assign req_key    = req_tdata[7:0];
   assign req_first  = req_tdata[8];
   assign store_char = (req_key == leib_pkg::KeyCr) ? leib_pkg::KeyNl : req_key;
   assign edit_dec   = leib_pkg::ptr_dec(edit_ff);
   assign edit_dec2  = leib_pkg::ptr_dec(edit_dec);
   assign edit_inc   = leib_pkg::ptr_inc(edit_ff);
   assign read_inc   = leib_pkg::ptr_inc(read_ff);

   assign req_tready = (state_ff == leib_pkg::StIdle);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_ff;

   leib_ram #(
      .Width(8),
      .Depth(leib_pkg::BufferDepth)
   ) u_line_store (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_en  (rd_en),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   always_comb begin
      state_in     = state_ff;
      read_in      = read_ff;
      commit_in    = commit_ff;
      edit_in      = edit_ff;
      first_in     = first_ff;
      res_in       = res_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      wr_en        = 1'b0;
      wr_addr      = leib_pkg::ptr_slot(edit_ff);
      wr_data      = store_char;
      rd_en        = 1'b0;
      rd_addr      = leib_pkg::ptr_slot(read_ff);

      unique case (state_ff)
         leib_pkg::StIdle: begin
            if (req_tvalid) begin
               res_in   = '0;
               state_in = leib_pkg::StOut;
               if (req_tuser) begin
                  if (read_ff == commit_ff) begin
                     res_in.read_status = leib_pkg::RdEmpty;
                  end else begin
                     rd_en    = 1'b1;
                     first_in = req_first;
                     state_in = leib_pkg::StRead;
                  end
               end else begin
                  case (req_key) inside
                     leib_pkg::KeyNone: begin
                     end
                     leib_pkg::KeyDump: begin
                        res_in.dump_request = 1'b1;
                     end
                     leib_pkg::KeyKill: begin
                        if (edit_ff != commit_ff) begin
                           rd_en    = 1'b1;
                           rd_addr  = leib_pkg::ptr_slot(edit_dec);
                           state_in = leib_pkg::StKill;
                        end
                     end
                     leib_pkg::KeyBs, leib_pkg::KeyDel: begin
                        if (edit_ff != commit_ff) begin
                           edit_in            = edit_dec;
                           res_in.erase_count = 8'd1;
                        end
                     end
                     default: begin
                        if (leib_pkg::ptr_dist(edit_ff, read_ff) <
                            leib_pkg::ptr_type'(leib_pkg::BufferDepth)) begin
                           wr_en             = 1'b1;
                           edit_in           = edit_inc;
                           res_in.echo_valid = 1'b1;
                           res_in.echo_char  = store_char;
                           if (store_char == leib_pkg::KeyNl ||
                               store_char == leib_pkg::KeyEof ||
                               leib_pkg::ptr_dist(edit_inc, read_ff) ==
                               leib_pkg::ptr_type'(leib_pkg::BufferDepth)) begin
                              commit_in         = edit_inc;
                              res_in.line_ready = 1'b1;
                           end
                        end
                     end
                  endcase
               end
            end
         end
         leib_pkg::StKill: begin
            if (rd_data == leib_pkg::KeyNl) begin
               state_in = leib_pkg::StOut;
            end else begin
               edit_in = edit_dec;
               if (res_ff.erase_count != leib_pkg::EraseMax) begin
                  res_in.erase_count = res_ff.erase_count + 8'd1;
               end
               if (edit_dec == commit_ff) begin
                  state_in = leib_pkg::StOut;
               end else begin
                  rd_en   = 1'b1;
                  rd_addr = leib_pkg::ptr_slot(edit_dec2);
               end
            end
         end
         leib_pkg::StRead: begin
            state_in = leib_pkg::StOut;
            if (rd_data == leib_pkg::KeyEof) begin
               if (first_ff) begin
                  read_in            = read_inc;
                  res_in.read_status = leib_pkg::RdEofUsed;
               end else begin
                  res_in.read_status = leib_pkg::RdEofKept;
               end
            end else begin
               read_in          = read_inc;
               res_in.read_char = rd_data;
               res_in.read_status = (rd_data == leib_pkg::KeyNl) ? leib_pkg::RdNewline
                                                                 : leib_pkg::RdChar;
            end
         end
         leib_pkg::StOut: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_in       = res_ff;
               state_in     = leib_pkg::StIdle;
            end
         end
         default: begin
            state_in = leib_pkg::StIdle;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= leib_pkg::StIdle;
         read_ff      <= '0;
         commit_ff    <= '0;
         edit_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         read_ff      <= read_in;
         commit_ff    <= commit_in;
         edit_ff      <= edit_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      first_ff <= first_in;
      res_ff   <= res_in;
      rsp_ff   <= rsp_in;
   end

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      leib_pkg::ptr_dist(edit_ff, read_ff) <= leib_pkg::ptr_type'(leib_pkg::BufferDepth))
      else $error("edit pointer runs more than a buffer ahead of read pointer");

   a_commit_order: assert property (@(posedge clock) disable iff (reset)
      leib_pkg::ptr_dist(commit_ff, read_ff) <= leib_pkg::ptr_dist(edit_ff, read_ff))
      else $error("commit pointer outside read..edit window");

   a_kill_nonempty: assert property (@(posedge clock) disable iff (reset)
      state_ff == leib_pkg::StKill |-> edit_ff != commit_ff)
      else $error("kill walk entered with nothing uncommitted");

   a_read_nonempty: assert property (@(posedge clock) disable iff (reset)
      state_ff == leib_pkg::StRead |-> read_ff != commit_ff)
      else $error("character read issued on empty buffer");

   a_read_advance: assert property (@(posedge clock) disable iff (reset)
      read_ff != $past(read_ff) |-> $past(state_ff) == leib_pkg::StRead)
      else $error("read pointer moved outside a read request");

endmodule
